>>> hdl/scba_pkg.sv
`default_nettype none
package scba_pkg;

   localparam int NUM_CLASSES    = 14;
   localparam int MAX_SMALL_SIZE = 640;
   localparam int CHUNK_BYTES    = 16384;
   localparam int MAX_CHUNKS     = 64;

   localparam int OP_W        = 2;
   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 20;
   localparam int STATUS_W    = 2;
   localparam int CLS_W       = 4;
   localparam int IDX_W       = 16;
   localparam int LINK_W      = IDX_W + 1;
   localparam int LINK_DEPTH  = 1 << IDX_W;
   localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int BSZ_W       = 13;
   localparam int OFF_W       = 18;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOCHUNK  = 2'd3;

   localparam logic [1:0] K_ALLOC  = 2'd0;
   localparam logic [1:0] K_FREE   = 2'd1;
   localparam logic [1:0] K_CLEAR  = 2'd2;
   localparam logic [1:0] K_DIRECT = 2'd3;

   localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {IDX_W{1'b0}}};

   typedef struct packed {
      logic [1:0]          kind;
      logic [STATUS_W-1:0] status;
      logic [CLS_W-1:0]    cls;
      logic [IDX_W-1:0]    idx;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
      logic [CLS_W-1:0]    cls;
   } rsp_type;

   function automatic logic [BSZ_W-1:0] class_bytes(input logic [CLS_W-1:0] i);
      logic [BSZ_W-1:0] r;
      if (i == '0) begin
         r = BSZ_W'(16);
      end else if (i <= CLS_W'(8)) begin
         r = BSZ_W'(i) << 5;
      end else if (i <= CLS_W'(12)) begin
         r = BSZ_W'(256) + (BSZ_W'(i - CLS_W'(8)) << 6);
      end else begin
         r = BSZ_W'(512) + (BSZ_W'(i - CLS_W'(12)) << 7);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/size_class_block_allocator_core.sv
`default_nettype none
// Size-class block allocator. Requests enter through a two-entry queue where
// they are classified; the executor then takes one request at a time and
// posts one response into a two-entry response queue. Free, clear and
// rejected requests are answered from the idle state, an allocate from a
// non-empty list takes one read of the link memory, and an allocate that
// carves a new chunk makes one link-memory write per carved block. The link
// memory is single ported and is not cleared after reset; its read data is
// only used from entries that have been written.
module size_class_block_allocator_core
   import scba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [SIZE_W-1:0]   req_request_size,
   input  wire logic [ADDR_W-1:0]   req_block_address,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [ADDR_W-1:0]        rsp_result_address,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [CLS_W-1:0]         rsp_size_class
);
   cmd_chan_type cmd_chan;
   logic         cmd_pop;

   scba_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_request_size  (req_request_size),
      .req_block_address (req_block_address),
      .cmd_chan          (cmd_chan),
      .cmd_pop           (cmd_pop)
   );

   scba_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_chan           (cmd_chan),
      .cmd_pop            (cmd_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_size_class     (rsp_size_class)
   );
endmodule
`default_nettype wire

>>> hdl/scba_ram.sv
`default_nettype none
module scba_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata <= mem[addr];
      end
   end
endmodule
`default_nettype wire

>>> hdl/scba_front.sv
`default_nettype none
module scba_front
   import scba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [SIZE_W-1:0] req_request_size,
   input  wire logic [ADDR_W-1:0] req_block_address,
   output cmd_chan_type           cmd_chan,
   input  wire logic              cmd_pop
);
   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   cmd_type    cmd;
   logic [CLS_W-1:0] cls;
   logic       found;

   always_comb begin
      cls   = '0;
      found = 1'b0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (SIZE_W'(class_bytes(CLS_W'(i))) >= req_request_size) begin
            cls   = CLS_W'(i);
            found = 1'b1;
         end
      end
      if (req_request_size > SIZE_W'(MAX_SMALL_SIZE)) begin
         found = 1'b0;
      end
   end

   always_comb begin
      cmd.kind   = K_DIRECT;
      cmd.status = ST_OK;
      cmd.cls    = '0;
      cmd.idx    = req_block_address[ADDR_W-1 -: IDX_W];
      if (req_opcode == OP_CLEAR) begin
         cmd.kind = K_CLEAR;
      end else if (req_opcode == OP_ALLOC || req_opcode == OP_FREE) begin
         if (req_request_size == '0) begin
            cmd.status = ST_NULL;
         end else if (!found) begin
            cmd.status = ST_OVERSIZE;
         end else begin
            cmd.kind = (req_opcode == OP_FREE) ? K_FREE : K_ALLOC;
            cmd.cls  = cls;
         end
      end
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push     = req_push && !req_full;
   assign pop      = cmd_pop && (cnt_ff != 2'd0);
   assign cmd_chan.valid = (cnt_ff != 2'd0);
   assign cmd_chan.cmd   = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cmd;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("front queue count out of range");
endmodule
`default_nettype wire

>>> hdl/scba_back.sv
`default_nettype none
module scba_back
   import scba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  cmd_chan_type             cmd_chan,
   output logic                     cmd_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [ADDR_W-1:0]        rsp_result_address,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [CLS_W-1:0]         rsp_size_class
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_POP   = 2'd1;
   localparam logic [1:0] S_CARVE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [LINK_W-1:0]      heads_ff [NUM_CLASSES];
   logic [LINK_W-1:0]      heads_in [NUM_CLASSES];
   logic [CHUNK_CNT_W-1:0] chunks_ff, chunks_in;
   cmd_type                cur_ff, cur_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [OFF_W-1:0]       off_ff, off_in;

   rsp_type    oq_ff [2];
   logic       owr_ff, ord_ff;
   logic [1:0] ocnt_ff;
   logic       opush, opop;
   rsp_type    orsp;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [LINK_W-1:0] ram_wdata, ram_rdata;

   logic [BSZ_W-1:0]  bsz;
   logic [ADDR_W-1:0] carve_a, carve_n;
   logic              carve_last;
   logic [LINK_W-1:0] head;

   function automatic logic [IDX_W-1:0] base_in_next(input logic [ADDR_W-1:0] b,
                                                     input logic [BSZ_W-1:0] s);
      logic [ADDR_W-1:0] a;
      a = b + ADDR_W'(s);
      return a[ADDR_W-1 -: IDX_W];
   endfunction

   scba_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_link (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign bsz        = class_bytes(cur_ff.cls);
   assign carve_a    = base_ff + ADDR_W'(off_ff);
   assign carve_n    = carve_a + ADDR_W'(bsz);
   assign carve_last = (off_ff + (OFF_W'(bsz) << 1)) > OFF_W'(CHUNK_BYTES);
   assign head       = heads_ff[cmd_chan.cmd.cls];

   always_comb begin
      state_in  = state_ff;
      heads_in  = heads_ff;
      chunks_in = chunks_ff;
      cur_in    = cur_ff;
      base_in   = base_ff;
      off_in    = off_ff;
      cmd_pop   = 1'b0;
      opush     = 1'b0;
      orsp      = '0;
      ram_we    = 1'b0;
      ram_addr  = cmd_chan.cmd.idx;
      ram_wdata = head;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_chan.valid && ocnt_ff != 2'd2) begin
               cmd_pop = 1'b1;
               unique case (cmd_chan.cmd.kind)
                  K_CLEAR: begin
                     for (int i = 0; i < NUM_CLASSES; i++) heads_in[i] = LINK_NULL;
                     chunks_in = '0;
                     opush     = 1'b1;
                  end
                  K_DIRECT: begin
                     orsp.status = cmd_chan.cmd.status;
                     opush       = 1'b1;
                  end
                  K_FREE: begin
                     ram_we    = 1'b1;
                     heads_in[cmd_chan.cmd.cls] = {1'b0, cmd_chan.cmd.idx};
                     orsp.cls  = cmd_chan.cmd.cls;
                     opush     = 1'b1;
                  end
                  K_ALLOC: begin
                     cur_in = cmd_chan.cmd;
                     if (!head[LINK_W-1]) begin
                        ram_addr   = head[IDX_W-1:0];
                        cur_in.idx = head[IDX_W-1:0];
                        state_in   = S_POP;
                     end else if (chunks_ff >= CHUNK_CNT_W'(MAX_CHUNKS)) begin
                        orsp.status = ST_NOCHUNK;
                        orsp.cls    = cmd_chan.cmd.cls;
                        opush       = 1'b1;
                     end else begin
                        base_in  = ADDR_W'(32'(chunks_ff) * CHUNK_BYTES);
                        off_in   = '0;
                        state_in = S_CARVE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            heads_in[cur_ff.cls] = ram_rdata;
            orsp.addr = {cur_ff.idx, 4'b0000};
            orsp.cls  = cur_ff.cls;
            opush     = 1'b1;
            state_in  = S_IDLE;
         end
         S_CARVE: begin
            ram_we    = 1'b1;
            ram_addr  = carve_a[ADDR_W-1 -: IDX_W];
            ram_wdata = carve_last ? LINK_NULL : {1'b0, carve_n[ADDR_W-1 -: IDX_W]};
            off_in    = off_ff + OFF_W'(bsz);
            if (carve_last) begin
               heads_in[cur_ff.cls] = (off_ff == '0) ? LINK_NULL :
                  {1'b0, base_in_next(base_ff, bsz)};
               chunks_in = chunks_ff + 1'b1;
               orsp.addr = base_ff;
               orsp.cls  = cur_ff.cls;
               opush     = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign opop               = rsp_pop && (ocnt_ff != 2'd0);
   assign rsp_empty          = (ocnt_ff == 2'd0);
   assign rsp_result_address = oq_ff[ord_ff].addr;
   assign rsp_status         = oq_ff[ord_ff].status;
   assign rsp_size_class     = oq_ff[ord_ff].cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         chunks_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) heads_ff[i] <= LINK_NULL;
         owr_ff    <= 1'b0;
         ord_ff    <= 1'b0;
         ocnt_ff   <= 2'd0;
      end else begin
         state_ff  <= state_in;
         chunks_ff <= chunks_in;
         heads_ff  <= heads_in;
         owr_ff    <= owr_ff ^ opush;
         ord_ff    <= ord_ff ^ opop;
         ocnt_ff   <= ocnt_ff + 2'(opush) - 2'(opop);
      end
      cur_ff  <= cur_in;
      base_ff <= base_in;
      off_ff  <= off_in;
      if (opush) begin
         oq_ff[owr_ff] <= orsp;
      end
   end

   a_carve_budget: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CARVE |-> chunks_ff < CHUNK_CNT_W'(MAX_CHUNKS))
      else $error("carving beyond chunk budget");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      opush |-> (ocnt_ff != 2'd2 || opop)) else $error("result queue overflow");
   a_pop_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !cmd_pop) else $error("request taken while busy");
endmodule
`default_nettype wire
